// File: hw/rtl/crt_pkg.sv
// crt_pkg: shared constants for the generalised CRT combiner.
// Used by crt_div, crt_mul, crt_noncoprime_combiner_top, crt_checker and the test. No dependencies.
package crt_pkg;

	localparam int MOD_W = 32;  // width of modulus and residue
	localparam int RES_W = 64;  // width of running modulus and remainder
	localparam int STS_W = 2;

	localparam logic [STS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STS_W-1:0] ST_NOSOL    = 2'd1;
	localparam logic [STS_W-1:0] ST_INVALID  = 2'd2;
	localparam logic [STS_W-1:0] ST_OVERFLOW = 2'd3;

endpackage

// File: hw/rtl/crt_div.sv
// crt_div: restoring divider, RES_W-bit dividend by MOD_W-bit divisor, one bit a cycle.
// Depends on crt_pkg. Divisor must be non-zero.
module crt_div import crt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RES_W-1:0] dividend,
	input  logic [MOD_W-1:0] divisor,
	output logic             done,
	output logic [RES_W-1:0] quotient,
	output logic [MOD_W-1:0] remainder
);
	localparam int CNT_W = $clog2(RES_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RES_W-1:0] quo_q;
	logic [MOD_W-1:0] rem_q;
	logic [MOD_W-1:0] dvs_q;
	logic [MOD_W:0]   sh;
	logic             ge;

	assign sh = {rem_q, quo_q[RES_W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RES_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[RES_W-2:0], ge};
			rem_q <= ge ? MOD_W'(sh - {1'b0, dvs_q}) : sh[MOD_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// File: hw/rtl/crt_mul.sv
// crt_mul: MOD_W x MOD_W multiplier with registered product and done, ready the cycle after start.
// Depends on crt_pkg.
module crt_mul import crt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MOD_W-1:0]   a,
	input  logic [MOD_W-1:0]   b,
	output logic               done,
	output logic [2*MOD_W-1:0] prod
);
	logic               done_q;
	logic [2*MOD_W-1:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= a * b;
		end
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule

// File: hw/rtl/crt_noncoprime_combiner_top.sv
// crt_noncoprime_combiner_top: generalised CRT combiner, sequencer plus shared units.
// Depends on crt_pkg, crt_div and crt_mul.
//
// Each beat (start high while busy low) carries one congruence x = residue (mod
// modulus). Beats of a set are folded into a running congruence whose modulus
// is the lcm of the moduli so far; the beat with last set produces one result,
// shown on solution/combined_modulus/status for exactly one cycle with valid
// high, after which the block is clear for the next set. The receiver cannot
// stall: it must take the result in that cycle. busy stays high from the
// accepting edge until the result (or, for a non-last beat, the end of the fold).
// The first beat of a set, an invalid beat and any beat after an error skip the
// fold. A fold runs every division through the single bit-serial divider: 7
// fixed divisions, plus 1 per gcd step and 2 per extended Euclid step. With
// 32-bit moduli each loop takes up to about 45 steps; products go through the
// single 32x32 multiplier.
// Status: 0 ok, 1 no solution, 2 invalid input (modulus 0 or residue >=
// modulus), 3 lcm beyond 64 bits. The first error of a set is kept; solution
// and combined_modulus read 0 on any error. A zero solution is reported as the lcm.
module crt_noncoprime_combiner_top import crt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MOD_W-1:0] modulus,
	input  logic [MOD_W-1:0] residue,
	input  logic             last,
	output logic             busy,
	output logic             valid,
	output logic [RES_W-1:0] solution,
	output logic [RES_W-1:0] combined_modulus,
	output logic [STS_W-1:0] status
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_GM   = 5'd1;   // M mod m
	localparam logic [4:0] S_GL   = 5'd2;   // gcd loop
	localparam logic [4:0] S_RM   = 5'd3;   // R mod m
	localparam logic [4:0] S_DG   = 5'd4;   // d / g
	localparam logic [4:0] S_MG   = 5'd5;   // m / g
	localparam logic [4:0] S_OV1  = 5'd6;   // M lo * mp
	localparam logic [4:0] S_OV2  = 5'd7;   // M hi * mp
	localparam logic [4:0] S_QG   = 5'd8;   // M / g
	localparam logic [4:0] S_AM   = 5'd9;   // (M/g) mod mp
	localparam logic [4:0] S_EU   = 5'd10;  // Euclid quotient
	localparam logic [4:0] S_EM   = 5'd11;  // q * t1
	localparam logic [4:0] S_ER   = 5'd12;  // mod mp
	localparam logic [4:0] S_KM   = 5'd13;  // dq * inv
	localparam logic [4:0] S_KR   = 5'd14;  // mod mp
	localparam logic [4:0] S_RK1  = 5'd15;  // M lo * k
	localparam logic [4:0] S_RK2  = 5'd16;  // M hi * k
	localparam logic [4:0] S_FIN  = 5'd17;

	logic [4:0]         state_q;
	logic               pend_q;
	logic [MOD_W-1:0]   m_q, r_q;
	logic               last_q;
	logic [RES_W-1:0]   big_m_q, big_r_q;
	logic [STS_W-1:0]   err_q;
	logic               first_q;
	logic [MOD_W-1:0]   ga_q, gb_q, g_q, dq_q, mp_q, t0_q, t1_q, q_q, k_q;
	logic [RES_W-1:0]   p1_q, nm_q, w_q;

	logic               valid_q;
	logic [RES_W-1:0]   sol_q, cm_q;
	logic [STS_W-1:0]   sts_q;

	logic               accept;
	logic               div_go, mul_go;
	logic [RES_W-1:0]   div_dvd;
	logic [MOD_W-1:0]   div_dvs;
	logic               div_done;
	logic [RES_W-1:0]   div_quo;
	logic [MOD_W-1:0]   div_rem;
	logic [MOD_W-1:0]   mul_a, mul_b;
	logic               mul_done;
	logic [2*MOD_W-1:0] mul_prod;
	logic [RES_W+MOD_W-1:0] ov_sum;
	logic [MOD_W-1:0]   d_val, t2_val;

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;

	// Operand selection for the shared divider and multiplier
	always_comb begin
		div_go  = 1'b0;
		mul_go  = 1'b0;
		div_dvd = '0;
		div_dvs = MOD_W'(1);
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_GM: begin div_dvd = big_m_q;            div_dvs = m_q;  div_go = !pend_q; end
			S_GL: begin div_dvd = RES_W'(ga_q);       div_dvs = gb_q;
				div_go = !pend_q && (gb_q != '0); end
			S_RM: begin div_dvd = big_r_q;            div_dvs = m_q;  div_go = !pend_q; end
			S_DG: begin div_dvd = RES_W'(dq_q);       div_dvs = g_q;  div_go = !pend_q; end
			S_MG: begin div_dvd = RES_W'(m_q);        div_dvs = g_q;  div_go = !pend_q; end
			S_QG: begin div_dvd = big_m_q;            div_dvs = g_q;  div_go = !pend_q; end
			S_AM: begin div_dvd = w_q;                div_dvs = mp_q; div_go = !pend_q; end
			S_EU: begin div_dvd = RES_W'(ga_q);       div_dvs = gb_q;
				div_go = !pend_q && (gb_q != '0); end
			S_ER: begin div_dvd = p1_q;               div_dvs = mp_q; div_go = !pend_q; end
			S_KR: begin div_dvd = p1_q;               div_dvs = mp_q; div_go = !pend_q; end
			S_OV1: begin mul_a = big_m_q[MOD_W-1:0];     mul_b = mp_q; mul_go = !pend_q; end
			S_OV2: begin mul_a = big_m_q[RES_W-1:MOD_W]; mul_b = mp_q; mul_go = !pend_q; end
			S_EM:  begin mul_a = q_q;                    mul_b = t1_q; mul_go = !pend_q; end
			S_KM:  begin mul_a = dq_q;                   mul_b = t0_q; mul_go = !pend_q; end
			S_RK1: begin mul_a = big_m_q[MOD_W-1:0];     mul_b = k_q;  mul_go = !pend_q; end
			S_RK2: begin mul_a = big_m_q[RES_W-1:MOD_W]; mul_b = k_q;  mul_go = !pend_q; end
			default: ;
		endcase
	end

	crt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	crt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// d = (r - R mod m) mod m
	assign d_val  = (r_q >= div_rem) ? r_q - div_rem : r_q + (m_q - div_rem);
	// t2 = (t0 - q*t1 mod n) mod n
	assign t2_val = (t0_q >= div_rem) ? t0_q - div_rem : t0_q + (mp_q - div_rem);
	// full M * mp; anything above 64 bits is overflow
	assign ov_sum = (RES_W+MOD_W)'(p1_q) + {mul_prod, {MOD_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			big_m_q <= '0;
			big_r_q <= '0;
			err_q   <= ST_OK;
			first_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (div_go || mul_go) begin
				pend_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						if (err_q == ST_OK) begin
							if (modulus == '0 || residue >= modulus) begin
								err_q <= ST_INVALID;
							end else if (first_q) begin
								big_m_q <= RES_W'(modulus);
								big_r_q <= RES_W'(residue);
							end else begin
								state_q <= S_GM;
							end
						end
					end
				end
				S_GM: if (pend_q && div_done) begin
					pend_q <= 1'b0; ga_q <= m_q; gb_q <= div_rem; state_q <= S_GL;
				end
				S_GL: begin
					if (!pend_q && gb_q == '0) begin
						g_q <= ga_q; state_q <= S_RM;
					end else if (pend_q && div_done) begin
						pend_q <= 1'b0; ga_q <= gb_q; gb_q <= div_rem;
					end
				end
				S_RM: if (pend_q && div_done) begin
					pend_q <= 1'b0; dq_q <= d_val; state_q <= S_DG;
				end
				S_DG: if (pend_q && div_done) begin
					pend_q <= 1'b0;
					if (div_rem != '0) begin
						err_q <= ST_NOSOL; state_q <= S_FIN;
					end else begin
						dq_q <= div_quo[MOD_W-1:0]; state_q <= S_MG;
					end
				end
				S_MG: if (pend_q && div_done) begin
					pend_q <= 1'b0; mp_q <= div_quo[MOD_W-1:0]; state_q <= S_OV1;
				end
				S_OV1: if (pend_q && mul_done) begin
					pend_q <= 1'b0; p1_q <= mul_prod; state_q <= S_OV2;
				end
				S_OV2: if (pend_q && mul_done) begin
					pend_q <= 1'b0;
					if (ov_sum[RES_W+MOD_W-1:RES_W] != '0) begin
						err_q <= ST_OVERFLOW; state_q <= S_FIN;
					end else begin
						nm_q <= ov_sum[RES_W-1:0]; state_q <= S_QG;
					end
				end
				S_QG: if (pend_q && div_done) begin
					pend_q <= 1'b0; w_q <= div_quo; state_q <= S_AM;
				end
				S_AM: if (pend_q && div_done) begin
					pend_q <= 1'b0;
					ga_q <= mp_q; gb_q <= div_rem;
					t0_q <= '0;
					t1_q <= (mp_q == MOD_W'(1)) ? '0 : MOD_W'(1);
					state_q <= S_EU;
				end
				S_EU: begin
					if (!pend_q && gb_q == '0) begin
						state_q <= S_KM;
					end else if (pend_q && div_done) begin
						pend_q <= 1'b0; q_q <= div_quo[MOD_W-1:0];
						ga_q <= gb_q; gb_q <= div_rem; state_q <= S_EM;
					end
				end
				S_EM: if (pend_q && mul_done) begin
					pend_q <= 1'b0; p1_q <= mul_prod; state_q <= S_ER;
				end
				S_ER: if (pend_q && div_done) begin
					pend_q <= 1'b0; t0_q <= t1_q; t1_q <= t2_val; state_q <= S_EU;
				end
				S_KM: if (pend_q && mul_done) begin
					pend_q <= 1'b0; p1_q <= mul_prod; state_q <= S_KR;
				end
				S_KR: if (pend_q && div_done) begin
					pend_q <= 1'b0; k_q <= div_rem; state_q <= S_RK1;
				end
				S_RK1: if (pend_q && mul_done) begin
					pend_q <= 1'b0; p1_q <= mul_prod; state_q <= S_RK2;
				end
				S_RK2: if (pend_q && mul_done) begin
					pend_q  <= 1'b0;
					// R + M*k stays below the new lcm, so 64 bits suffice
					big_r_q <= big_r_q + p1_q + {mul_prod[MOD_W-1:0], {MOD_W{1'b0}}};
					big_m_q <= nm_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					// a new set starts after the last beat
					first_q <= last_q;
					if (last_q) begin
						valid_q <= 1'b1;
						sts_q   <= err_q;
						if (err_q == ST_OK) begin
							sol_q <= (big_r_q != '0) ? big_r_q : big_m_q;
							cm_q  <= big_m_q;
						end else begin
							sol_q <= '0;
							cm_q  <= '0;
						end
						big_m_q <= '0;
						big_r_q <= '0;
						err_q   <= ST_OK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_q    <= modulus;
			r_q    <= residue;
			last_q <= last;
		end
	end

	assign valid            = valid_q;
	assign solution         = sol_q;
	assign combined_modulus = cm_q;
	assign status           = sts_q;

	// an accepted beat always has busy high in the cycle after it is taken
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted beat did not raise busy");

	// result appears only as the sequencer returns to idle
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy && $past(busy)) else $error("result outside end of set");

	// error results carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_OK |-> solution == '0 && combined_modulus == '0)
		else $error("error result with non-zero payload");

	// good results have a non-zero lcm and a solution no larger than it
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_OK |-> combined_modulus != '0 && solution <= combined_modulus)
		else $error("solution out of range");
endmodule

// File: verif/crt_checker.sv
// crt_checker: predicts and scores the results of crt_noncoprime_combiner_top.
// Depends on crt_pkg. Watches the input and result channels; exports counts.
module crt_checker import crt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [MOD_W-1:0] modulus,
	input  logic [MOD_W-1:0] residue,
	input  logic             last,
	input  logic             valid,
	input  logic [RES_W-1:0] solution,
	input  logic [RES_W-1:0] combined_modulus,
	input  logic [STS_W-1:0] status,
	output int               mismatches,
	output int               pending
);

	typedef struct packed {
		logic [RES_W-1:0] sol;
		logic [RES_W-1:0] lcm;
		logic [STS_W-1:0] sts;
	} crt_result_t;

	crt_result_t      awaited_results[$];
	logic [RES_W-1:0] lcm_acc;
	logic [RES_W-1:0] rem_acc;
	logic [STS_W-1:0] set_err;
	logic             set_fresh;

	assign pending = awaited_results.size();

	function automatic logic [RES_W-1:0] gcd_of(logic [RES_W-1:0] a, logic [RES_W-1:0] b);
		logic [RES_W-1:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// inverse of a modulo n (gcd 1); n fits 32 bits so signed 64 is ample
	function automatic longint inverse_of(longint a, longint n);
		longint r0, r1, t0, t1, q, tmp;
		r0 = n; r1 = a % n; t0 = 0; t1 = 1;
		if (n == 1) return 0;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1; r0 = r1; r1 = tmp;
			tmp = t0 - q * t1; t0 = t1; t1 = tmp;
		end
		return (t0 % n + n) % n;
	endfunction

	task automatic report(string what, logic [RES_W-1:0] got, logic [RES_W-1:0] want);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic fold_in(logic [RES_W-1:0] m, logic [RES_W-1:0] r);
		logic [RES_W-1:0] g, mp, d, k;
		logic [127:0]     wide;
		g  = gcd_of(lcm_acc, m);
		mp = m / g;
		d  = (r + m - rem_acc % m) % m;
		if (d % g != 0) begin
			set_err = ST_NOSOL;
			return;
		end
		wide = 128'(lcm_acc) * 128'(mp);
		if (wide[127:64] != 0) begin
			set_err = ST_OVERFLOW;
			return;
		end
		k = 64'((128'(d / g) * 128'(inverse_of(longint'((lcm_acc / g) % mp),
			longint'(mp)))) % 128'(mp));
		rem_acc = rem_acc + lcm_acc * k;
		lcm_acc = wide[63:0];
	endtask

	task automatic take_beat(logic [RES_W-1:0] m, logic [RES_W-1:0] r, logic fin);
		crt_result_t res;
		if (set_err == ST_OK) begin
			if (m == 0 || r >= m) set_err = ST_INVALID;
			else if (set_fresh) begin
				lcm_acc = m;
				rem_acc = r;
			end else fold_in(m, r);
		end
		set_fresh = 1'b0;
		if (fin) begin
			if (set_err == ST_OK) begin
				res.sol = (rem_acc != 0) ? rem_acc : lcm_acc;
				res.lcm = lcm_acc;
			end else begin
				res.sol = '0;
				res.lcm = '0;
			end
			res.sts = set_err;
			awaited_results.push_back(res);
			lcm_acc = '0; rem_acc = '0; set_err = ST_OK; set_fresh = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		crt_result_t want;
		if (!arst_n) begin
			lcm_acc = '0; rem_acc = '0; set_err = ST_OK; set_fresh = 1'b1;
			mismatches = 0;
		end else begin
			if (valid) begin
				if (awaited_results.size() == 0) begin
					$display("MISMATCH unexpected result at %0t", $time);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (solution !== want.sol) report("solution", solution, want.sol);
					if (combined_modulus !== want.lcm)
						report("combined_modulus", combined_modulus, want.lcm);
					if (status !== want.sts) report("status", 64'(status), 64'(want.sts));
				end
			end
			if (start && !busy) take_beat(64'(modulus), 64'(residue), last);
		end
	end

endmodule

// File: verif/crt_noncoprime_combiner_top_test.sv
// crt_noncoprime_combiner_top_test: stimulus and verdict for the CRT combiner.
// Depends on crt_pkg, crt_noncoprime_combiner_top and crt_checker.
module crt_noncoprime_combiner_top_test;
	import crt_pkg::*;

	localparam int STALL_LIMIT = 60000;  // covers the worst fold, plus idle gaps

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [MOD_W-1:0] modulus = '0;
	logic [MOD_W-1:0] residue = '0;
	logic             last = 1'b0;
	logic             busy, valid;
	logic [RES_W-1:0] solution, combined_modulus;
	logic [STS_W-1:0] status;
	int               mismatches, pending;
	int               idle_pct = 0;   // chance in a hundred of a gap cycle before a beat
	int               quiet_cycles = 0;

	always #5 clk = ~clk;

	crt_noncoprime_combiner_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .modulus(modulus),
		.residue(residue), .last(last), .busy(busy), .valid(valid),
		.solution(solution), .combined_modulus(combined_modulus), .status(status)
	);

	crt_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .modulus(modulus),
		.residue(residue), .last(last), .valid(valid), .solution(solution),
		.combined_modulus(combined_modulus), .status(status),
		.mismatches(mismatches), .pending(pending)
	);

	// watchdog: too long with no beat and no result means the block has hung
	always @(posedge clk) begin
		if ((start && !busy) || valid) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// one beat: optional gap, then hold start until busy is seen low; start is
	// assigned only once per edge, so back-to-back beats keep it high
	task automatic send_beat(logic [MOD_W-1:0] m, logic [MOD_W-1:0] r, logic fin);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		modulus <= m;
		residue <= r;
		last    <= fin;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// pick a modulus; mostly small so folds stay short, now and then full width
	function automatic logic [MOD_W-1:0] pick_modulus();
		case ($urandom_range(9))
			0: return $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
			1, 2: return $urandom_range(1, 16);
			default: return $urandom_range(1, 4000) * $urandom_range(1, 12);
		endcase
	endfunction

	// a consistent set from a hidden 64-bit value; noise breaks some beats
	task automatic send_set();
		logic [63:0]      hidden;
		logic [MOD_W-1:0] m, r;
		int               n, noise;
		hidden = {$urandom, $urandom};
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			m = pick_modulus();
			r = MOD_W'(hidden % 64'(m));
			noise = $urandom_range(99);
			if (noise < 8) r = $urandom;                 // likely no solution or invalid
			else if (noise < 11) m = '0;                 // invalid modulus
			else if (noise < 14) r = m + $urandom_range(3); // residue at/above modulus
			send_beat(m, r, i == n - 1);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		idle_pct = 25;
		send_beat(32'd1, 32'd0, 1'b1);                      // trivial modulus
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);      // widest modulus, top residue
		send_beat(32'd0, 32'd0, 1'b1);                      // zero modulus
		send_beat(32'd7, 32'd7, 1'b1);                      // residue equal to modulus
		send_beat(32'd3, 32'd0, 1'b0);                      // zero solution gives the lcm
		send_beat(32'd5, 32'd0, 1'b1);
		send_beat(32'd4, 32'd1, 1'b0);                      // non-coprime, consistent
		send_beat(32'd6, 32'd3, 1'b1);
		send_beat(32'd4, 32'd1, 1'b0);                      // non-coprime, inconsistent
		send_beat(32'd6, 32'd2, 1'b0);
		send_beat(32'd5, 32'd9, 1'b1);                      // later invalid: first error kept
		send_beat(32'hFFFF_FFFF, 32'h5555_5555, 1'b0);      // lcm beyond 64 bits
		send_beat(32'hFFFF_FFFB, 32'hAAAA_AAAA, 1'b0);
		send_beat(32'hFFFF_FFF1, 32'h0000_0001, 1'b1);
		send_beat(32'hFFFF_FFFE, 32'hFFFF_FFFD, 1'b0);      // big non-coprime pair
		send_beat(32'hFFFF_FFFC, 32'h0000_0001, 1'b1);
		send_beat(32'd0, 32'd0, 1'b0);                      // invalid first, then valid
		send_beat(32'd9, 32'd2, 1'b1);

		// let everything drain before going on; one edge so the last beat is counted
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// random sets over three idling regimes
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 25 : (phase == 1) ? 87 : 0;
			repeat (11) send_set();
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/crt_pkg.sv
hw/rtl/crt_div.sv
hw/rtl/crt_mul.sv
hw/rtl/crt_noncoprime_combiner_top.sv
verif/crt_checker.sv
verif/crt_noncoprime_combiner_top_test.sv
